// File: rtl/sha1_stream_hasher_assert.svh
// Assertion macros shared by the hasher modules.
`ifndef SHA1_STREAM_HASHER_ASSERT_SVH
`define SHA1_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif
`endif

// File: rtl/sha1_pkg.sv
// Shared types, constants and round functions of the SHA-1 hasher.
package sha1_pkg;
  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned ROUND_COUNT = 80;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Commands handed from the packer to the compression engine.
  localparam logic [1:0] CMD_BLOCK = 2'd0;  // compress, keep chaining
  localparam logic [1:0] CMD_FINAL = 2'd1;  // compress, then emit digest and reinit

  typedef struct packed {
    logic [1:0]   cmd;
    logic [511:0] block;
  } sha_job_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) f = (b & c) | (~b & d);
    else if (r >= 7'd40 && r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction
endpackage

// File: rtl/sha1_stream_if.sv
// Valid/ready channel interfaces of the hasher.
interface sha1_in_if import sha1_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1_out_if import sha1_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/sha1_stream_hasher.sv
// Top level of the streaming SHA-1 hasher.
// Usage: the in channel takes one transaction per message byte (byte_present
// high) and a final transaction with end_of_message high, which may carry a
// last byte or none. The out channel returns five transactions per message:
// digest words h0..h4 with word_index 0..4 and last_word set on the fifth.
// Throughput: bytes are taken one per cycle while the job queue has room; each
// 64-byte block runs through the compression engine as a load, 80 rounds (one
// per cycle) and an add, so a long stream is bounded by the single round unit.
// The front end stalls when the two-entry job queue is full.
// The first digest word follows the final transaction once the padding blocks
// are compressed, one or two depending on whether padding needs two blocks.
// Reset: synchronous, active low; the chain value returns to the SHA-1
// initial values and all queues empty. No clearing pass is needed.
// A stalled receiver holds the engine on the current digest word; the
// front end keeps filling blocks until the queue is full.
module sha1_stream_hasher import sha1_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  sha1_in_if.sink    in_ch,
  sha1_out_if.source out_ch
);
  logic     pk_valid, pk_ready, q_valid, q_ready;
  sha_job_t pk_job, q_job;

  sha1_packer u_packer (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .job_valid(pk_valid), .job_ready(pk_ready), .job(pk_job)
  );

  sha1_job_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(pk_valid), .wr_ready(pk_ready), .wr_job(pk_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_job(q_job)
  );

  sha1_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job), .out_ch(out_ch)
  );
endmodule

// File: rtl/sha1_packer.sv
// Front end: packs bytes into blocks, pads on end of message, issues jobs.
module sha1_packer import sha1_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  sha1_in_if.sink  in_ch,
  output logic     job_valid,
  input  logic     job_ready,
  output sha_job_t job
);
  localparam logic [1:0] ST_ABSORB = 2'd0;
  localparam logic [1:0] ST_PAD    = 2'd1;  // pad byte to place
  localparam logic [1:0] ST_LEN    = 2'd2;  // length block to issue

  logic [1:0]   state_r, state_nxt;
  logic [511:0] buf_r, buf_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic         jv_r, jv_nxt;
  sha_job_t     job_r, job_nxt;
  logic         busy;

  assign busy = jv_r && !job_ready;
  assign in_ch.ready = (state_r == ST_ABSORB) && !busy;
  assign job_valid = jv_r;
  assign job = job_r;

  // Byte insertion into the block buffer at the current position.
  function automatic logic [511:0] put(input logic [511:0] b, input logic [5:0] p,
                                       input logic [7:0] v);
    logic [511:0] r;
    r = b;
    r[511 - 8*p -: 8] = v;
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    buf_nxt = buf_r;
    pos_nxt = pos_r;
    bits_nxt = bits_r;
    jv_nxt = busy;
    job_nxt = job_r;
    case (state_r)
      ST_ABSORB: begin
        if (in_ch.valid && in_ch.ready) begin
          if (in_ch.byte_present) begin
            bits_nxt = bits_r + 64'd8;
            if (pos_r == 6'd63) begin
              jv_nxt = 1'b1;
              job_nxt.cmd = CMD_BLOCK;
              job_nxt.block = put(buf_r, pos_r, in_ch.data_byte);
              buf_nxt = '0;
            end else begin
              buf_nxt = put(buf_r, pos_r, in_ch.data_byte);
            end
            pos_nxt = pos_r + 6'd1;
          end
          if (in_ch.end_of_message) state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (!busy) begin
          buf_nxt = put(buf_r, pos_r, PAD_BYTE);
          if (pos_r >= 6'd56) begin
            jv_nxt = 1'b1;
            job_nxt.cmd = CMD_BLOCK;
            job_nxt.block = buf_nxt;
            buf_nxt = '0;
          end
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        if (!busy) begin
          jv_nxt = 1'b1;
          job_nxt.cmd = CMD_FINAL;
          job_nxt.block = {buf_r[511:64], bits_r};
          buf_nxt = '0;
          pos_nxt = '0;
          bits_nxt = '0;
          state_nxt = ST_ABSORB;
        end
      end
      default: state_nxt = ST_ABSORB;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ABSORB;
      buf_r <= '0;
      pos_r <= '0;
      bits_r <= '0;
      jv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      buf_r <= buf_nxt;
      pos_r <= pos_nxt;
      bits_r <= bits_nxt;
      jv_r <= jv_nxt;
    end
    job_r <= job_nxt;
  end
endmodule

// File: rtl/sha1_job_queue.sv
// Two-entry queue of block jobs between packer and engine.
module sha1_job_queue import sha1_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  sha_job_t wr_job,
  output logic     rd_valid,
  input  logic     rd_ready,
  output sha_job_t rd_job
);
  `include "sha1_stream_hasher_assert.svh"
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  sha_job_t mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = cnt_r != (PW+1)'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;
  assign rd_job = mem_r[rp_r];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + PW'(1);
      if (rd_en) rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(wr_en) - (PW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_job;
  end

  `SHA_ASSERT_IMPL(a_cnt_bound, clk, rst_n, cnt_r <= (PW+1)'(QUEUE_DEPTH), "queue overfilled")
  `SHA_ASSERT_NEXT(a_full_hold, clk, rst_n, !wr_ready && !rd_en, !wr_ready, "full flag lost")
  `SHA_ASSERT_NEXT(a_empty_stay, clk, rst_n, !rd_valid && !wr_en, !rd_valid, "empty flag lost")
endmodule

// File: rtl/sha1_engine.sv
// Back end: 80-round compression, one round per cycle, and digest output.
module sha1_engine import sha1_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  sha_job_t  job,
  sha1_out_if.source out_ch
);
  `include "sha1_stream_hasher_assert.svh"
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  state_r;
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [16];
  logic [6:0]  rnd_r;
  logic        fin_r;
  logic [2:0]  idx_r;
  logic [31:0] wt, t;

  assign job_ready = state_r == ST_IDLE;
  assign out_ch.valid = state_r == ST_OUT;
  assign out_ch.digest_word = h_r[idx_r];
  assign out_ch.word_index = idx_r;
  assign out_ch.last_word = idx_r == 3'd4;

  // Message schedule and round datapath.
  always_comb begin
    if (rnd_r < 7'd16) wt = w_r[0];
    else begin
      wt = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
      wt = {wt[30:0], wt[31]};
    end
    t = {a_r[26:0], a_r[31:27]} + round_f(rnd_r, b_r, c_r, d_r) + e_r + round_k(rnd_r) + wt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      h_r[0] <= H0_INIT; h_r[1] <= H1_INIT; h_r[2] <= H2_INIT;
      h_r[3] <= H3_INIT; h_r[4] <= H4_INIT;
      rnd_r <= '0;
      idx_r <= '0;
      fin_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            for (int i = 0; i < 16; i++) w_r[i] <= job.block[511 - 32*i -: 32];
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
            fin_r <= job.cmd == CMD_FINAL;
            rnd_r <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wt;
          e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]}; b_r <= a_r; a_r <= t;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'(ROUND_COUNT - 1)) state_r <= ST_ADD;
        end
        ST_ADD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
          rnd_r <= '0;
          idx_r <= '0;
          state_r <= fin_r ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            if (idx_r == 3'd4) begin
              h_r[0] <= H0_INIT; h_r[1] <= H1_INIT; h_r[2] <= H2_INIT;
              h_r[3] <= H3_INIT; h_r[4] <= H4_INIT;
              state_r <= ST_IDLE;
            end
            idx_r <= idx_r + 3'd1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `SHA_ASSERT_IMPL(a_idx_bound, clk, rst_n, state_r != ST_OUT || idx_r <= 3'd4, "bad word index")
  `SHA_ASSERT_NEXT(a_run_end, clk, rst_n, state_r == ST_RUN && rnd_r == 7'(ROUND_COUNT - 1),
                   state_r == ST_ADD, "round count off")
  `SHA_ASSERT_IMPL(a_rnd_idle, clk, rst_n, state_r != ST_IDLE || rnd_r == '0, "round nonzero idle")
endmodule
